// File: rtl/multi_class_priority_deque_unit_macros.svh
// Assertion macros shared by the deque unit; they sample on clk and are disabled during reset.
`ifndef MULTI_CLASS_PRIORITY_DEQUE_UNIT_MACROS_SVH
`define MULTI_CLASS_PRIORITY_DEQUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mcpd_pkg.sv
// Package for the deque unit: defaults, field widths, opcodes and result codes.
`default_nettype none

package mcpd_pkg;

	// Defaults for the top-level parameters.
	localparam int NUM_CLASSES_DEF     = 16;
	localparam int SLOTS_PER_CLASS_DEF = 8;
	localparam int TAG_WIDTH_DEF       = 16;

	// Widths of the port fields.
	localparam int CLASS_W       = 4;
	localparam int TAG_FIELD_W   = 16;
	localparam int CODE_W        = 2;
	localparam int COUNT_FIELD_W = 4;

	// Opcodes.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	// Result codes.
	typedef enum logic [CODE_W-1:0] {
		RC_ADDED = 2'd0,
		RC_FULL  = 2'd1,
		RC_TAKEN = 2'd2,
		RC_EMPTY = 2'd3
	} result_code_t;

endpackage

`default_nettype wire

// File: rtl/multi_class_priority_deque_unit.sv
// Top level of the multi-class bounded deque with urgent head insert.
//
// Usage: an input beat on the in_valid/in_ready channel either adds an entry
// (opcode add) to the class named by class_index, at the head when urgent is
// set or at the tail otherwise, or takes the head entry of that class (opcode
// take). Every input beat produces exactly one output beat on the
// out_valid/out_ready channel carrying result_code, taken_tag, taken_urgent
// and the class's entry count after the operation.
// A beat accepted on the input is registered into stage one, and its result
// is then written into the result register, which drives out_valid.
// Throughput is one beat per cycle while the receiver does not stall, set
// by the single pass through stage one: one lookup of the class count and
// head pointer, one slot memory access and one count update per beat.
// Each class is a ring buffer of SLOTS_PER_CLASS entries in a shared slot
// memory; an urgent add moves the head pointer back one slot, so no entries
// physically shift.
// Reset clears all class counts and head pointers; the slot memory is not
// cleared and needs no clearing pass, since only written slots are ever read.
// When the receiver stalls, the result register holds and stage one stalls
// behind it; in_ready then drops in the same cycle if stage one holds a beat.
`default_nettype none
`include "multi_class_priority_deque_unit_macros.svh"

module multi_class_priority_deque_unit #(
	parameter int NUM_CLASSES     = mcpd_pkg::NUM_CLASSES_DEF,
	parameter int SLOTS_PER_CLASS = mcpd_pkg::SLOTS_PER_CLASS_DEF,
	parameter int TAG_WIDTH       = mcpd_pkg::TAG_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Input channel.
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               opcode,
	input  wire logic [mcpd_pkg::CLASS_W-1:0]       class_index,
	input  wire logic                               urgent,
	input  wire logic [mcpd_pkg::TAG_FIELD_W-1:0]   entry_tag,
	// Output channel.
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mcpd_pkg::CODE_W-1:0]             result_code,
	output logic [mcpd_pkg::TAG_FIELD_W-1:0]        taken_tag,
	output logic                                    taken_urgent,
	output logic [mcpd_pkg::COUNT_FIELD_W-1:0]      class_count
);
	import mcpd_pkg::*;

	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);
	localparam int PTR_W  = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
	localparam int SUM_W  = $clog2(2 * SLOTS_PER_CLASS) + 1;
	localparam int DEPTH  = NUM_CLASSES * SLOTS_PER_CLASS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MEM_W  = TAG_WIDTH + 1;

	// Stage one: the registered input beat.
	logic                 valid_s1;
	logic                 op_s1;
	logic [CLASS_W-1:0]   class_s1;
	logic                 urg_s1;
	logic [TAG_WIDTH-1:0] tag_s1;

	// Stage two: the result register.
	logic                 valid_s2;
	result_code_t         code_s2;
	logic [CNT_W-1:0]     count_s2;
	logic [MEM_W-1:0]     rd_s2;

	// Per-class state; reset clears it.
	logic [CNT_W-1:0]     counts_q [NUM_CLASSES];
	logic [PTR_W-1:0]     heads_q  [NUM_CLASSES];

	// Slot memory: urgent flag above the tag.
	logic [MEM_W-1:0]     slot_mem [DEPTH];

	logic                 s2_free;
	logic                 advance;
	logic                 cls_ok;
	logic [CLS_W-1:0]     cls_idx;
	logic [CNT_W-1:0]     cnt_cur;
	logic [PTR_W-1:0]     head_cur;
	logic [PTR_W-1:0]     head_dec;
	logic [PTR_W-1:0]     head_inc;
	logic [SUM_W-1:0]     tail_sum;
	logic [PTR_W-1:0]     tail_slot;
	logic [ADDR_W-1:0]    slot_addr;
	logic [PTR_W-1:0]     slot_sel;
	logic                 wr_en;
	logic                 rd_en;
	logic [CNT_W-1:0]     cnt_nxt;
	logic [PTR_W-1:0]     head_nxt;
	result_code_t         code_nxt;

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Look up the addressed class. An index past the last class reads as an
	// empty class and changes nothing.
	assign cls_ok   = 32'(class_s1) < 32'(NUM_CLASSES);
	assign cls_idx  = CLS_W'(class_s1);
	assign cnt_cur  = cls_ok ? counts_q[cls_idx] : '0;
	assign head_cur = cls_ok ? heads_q[cls_idx] : '0;

	// Ring arithmetic within the class; the tail sum stays below twice the
	// slot count, so one compare and subtract wraps it.
	assign head_dec  = (head_cur == '0) ? PTR_W'(SLOTS_PER_CLASS - 1) : head_cur - 1'b1;
	assign head_inc  = (head_cur == PTR_W'(SLOTS_PER_CLASS - 1)) ? '0 : head_cur + 1'b1;
	assign tail_sum  = SUM_W'(head_cur) + SUM_W'(cnt_cur);
	assign tail_slot = (tail_sum >= SUM_W'(SLOTS_PER_CLASS))
		? PTR_W'(tail_sum - SUM_W'(SLOTS_PER_CLASS)) : PTR_W'(tail_sum);
	assign slot_addr = ADDR_W'(cls_idx) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(slot_sel);

	always_comb begin
		code_nxt = RC_FULL;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		cnt_nxt  = cnt_cur;
		head_nxt = head_cur;
		slot_sel = head_cur;
		priority if (!cls_ok) begin
			code_nxt = (op_s1 == OP_TAKE) ? RC_EMPTY : RC_FULL;
		end else if (op_s1 == OP_ADD) begin
			if (cnt_cur >= CNT_W'(SLOTS_PER_CLASS)) begin
				code_nxt = RC_FULL;
			end else begin
				code_nxt = RC_ADDED;
				wr_en    = 1'b1;
				cnt_nxt  = cnt_cur + 1'b1;
				if (urg_s1) begin
					slot_sel = head_dec;
					head_nxt = head_dec;
				end else begin
					slot_sel = tail_slot;
				end
			end
		end else begin
			if (cnt_cur == '0) begin
				code_nxt = RC_EMPTY;
			end else begin
				code_nxt = RC_TAKEN;
				rd_en    = 1'b1;
				cnt_nxt  = cnt_cur - 1'b1;
				head_nxt = head_inc;
			end
		end
	end

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= opcode;
			class_s1 <= class_index;
			urg_s1   <= urgent;
			tag_s1   <= TAG_WIDTH'(entry_tag);
		end
	end

	// Class counts and head pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				counts_q[i] <= '0;
				heads_q[i]  <= '0;
			end
		end else if (advance && cls_ok) begin
			counts_q[cls_idx] <= cnt_nxt;
			heads_q[cls_idx]  <= head_nxt;
		end
	end

	// Slot memory: one write or one registered read per beat.
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			slot_mem[slot_addr] <= {urg_s1, tag_s1};
		end
		if (advance && rd_en) begin
			rd_s2 <= slot_mem[slot_addr];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_s2  <= code_nxt;
			count_s2 <= cnt_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign result_code  = code_s2;
	assign taken_tag    = (code_s2 == RC_TAKEN) ? TAG_FIELD_W'(rd_s2[TAG_WIDTH-1:0]) : '0;
	assign taken_urgent = (code_s2 == RC_TAKEN) ? rd_s2[TAG_WIDTH] : 1'b0;
	assign class_count  = COUNT_FIELD_W'(count_s2);

	// A class never holds more entries than it has slots.
	`MCPD_ASSERT_SAME(a_count_bound, valid_s1, cnt_cur <= CNT_W'(SLOTS_PER_CLASS), "class count above slot count")

	// A take from a non-empty class lowers its stored count by one.
	`MCPD_ASSERT_NEXT(a_take_decrements, advance && cls_ok && op_s1 == OP_TAKE && cnt_cur != '0, counts_q[$past(cls_idx)] == $past(cnt_cur) - 1'b1, "take did not decrement count")

	// A successful add always leaves at least one entry in the class.
	`MCPD_ASSERT_SAME(a_added_nonempty, valid_s2 && code_s2 == RC_ADDED, count_s2 != '0, "added result with zero count")

	// The input side stalls only behind a full, stalled pipeline.
	`MCPD_ASSERT_SAME(a_stall_cause, !in_ready, valid_s1 && valid_s2 && !out_ready, "input stalled without output stall")

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the multi-class bounded deque with urgent head insert.
`timescale 1ns / 1ps

module tb;
	import mcpd_pkg::*;

	localparam int CLASSES = NUM_CLASSES_DEF;
	localparam int SLOTS   = SLOTS_PER_CLASS_DEF;

	// One result beat as the block should produce it.
	typedef struct packed {
		result_code_t                code;
		logic [TAG_FIELD_W-1:0]      tag;
		logic                        urg;
		logic [COUNT_FIELD_W-1:0]    count;
	} outcome_t;

	// Every input gets a known value at time zero.
	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        opcode      = OP_ADD;
	logic [CLASS_W-1:0]          class_index = '0;
	logic                        urgent      = 1'b0;
	logic [TAG_FIELD_W-1:0]      entry_tag   = '0;
	logic                        out_ready   = 1'b0;
	logic                        in_ready;
	logic                        out_valid;
	logic [CODE_W-1:0]           result_code;
	logic [TAG_FIELD_W-1:0]      taken_tag;
	logic                        taken_urgent;
	logic [COUNT_FIELD_W-1:0]    class_count;

	// Shadow copy of every class queue; slot zero is the head.
	logic [TAG_FIELD_W-1:0]      shadow_tag [CLASSES][SLOTS];
	logic                        shadow_urg [CLASSES][SLOTS];
	int                          fill_count [CLASSES];

	// Results predicted at acceptance and not yet seen on the output.
	outcome_t                    outcomes_due [$];

	// Idling knobs, in percent of cycles, changed per phase.
	int                          idle_pct  = 0;
	int                          stall_pct = 0;

	int                          errors     = 0;
	int                          beats_sent = 0;
	int                          code_tally [4];

	multi_class_priority_deque_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.class_index  (class_index),
		.urgent       (urgent),
		.entry_tag    (entry_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_code  (result_code),
		.taken_tag    (taken_tag),
		.taken_urgent (taken_urgent),
		.class_count  (class_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one operation to the shadow queues and returns the result it must cause.
	// An urgent add shifts the class back by one slot and lands at the head; a take
	// shifts everything forward. Urgent flags travel with their tags.
	function automatic outcome_t deque_outcome(input logic op, input logic [CLASS_W-1:0] cls,
			input logic urg, input logic [TAG_FIELD_W-1:0] tag);
		outcome_t res;
		int       n;
		res = '0;
		res.code = RC_ADDED;
		// A class the block does not have is ignored; only reachable with fewer classes.
		if (cls >= CLASSES) begin
			res.code = (op == OP_TAKE) ? RC_EMPTY : RC_FULL;
			return res;
		end
		n = fill_count[cls];
		if (op == OP_ADD) begin
			if (n >= SLOTS) begin
				// Full class: rejected, nothing moves.
				res.code  = RC_FULL;
				res.count = COUNT_FIELD_W'(n);
			end else begin
				if (urg) begin
					for (int i = n; i > 0; i--) begin
						shadow_tag[cls][i] = shadow_tag[cls][i-1];
						shadow_urg[cls][i] = shadow_urg[cls][i-1];
					end
					shadow_tag[cls][0] = tag;
					shadow_urg[cls][0] = 1'b1;
				end else begin
					shadow_tag[cls][n] = tag;
					shadow_urg[cls][n] = 1'b0;
				end
				fill_count[cls] = n + 1;
				res.code  = RC_ADDED;
				res.count = COUNT_FIELD_W'(n + 1);
			end
		end else if (n == 0) begin
			// Take from an empty class: the count must stay at zero.
			res.code = RC_EMPTY;
		end else begin
			res.code = RC_TAKEN;
			res.tag  = shadow_tag[cls][0];
			res.urg  = shadow_urg[cls][0];
			for (int i = 0; i + 1 < n; i++) begin
				shadow_tag[cls][i] = shadow_tag[cls][i+1];
				shadow_urg[cls][i] = shadow_urg[cls][i+1];
			end
			fill_count[cls] = n - 1;
			res.count = COUNT_FIELD_W'(n - 1);
		end
		return res;
	endfunction

	// Output side. The stall decision for the next edge is made here too, so the
	// ready value seen at an edge is always the one driven at the edge before.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcomes_due.size() == 0) begin
				$display("%0t: result beat with nothing expected (code %0d tag %h urgent %0d count %0d)",
					$time, result_code, taken_tag, taken_urgent, class_count);
				errors++;
			end else begin
				want = outcomes_due.pop_front();
				code_tally[want.code]++;
				if (result_code !== want.code) begin
					$display("%0t: result_code expected %0d, got %0d", $time, want.code, result_code);
					errors++;
				end
				if (taken_tag !== want.tag) begin
					$display("%0t: taken_tag expected %h, got %h", $time, want.tag, taken_tag);
					errors++;
				end
				if (taken_urgent !== want.urg) begin
					$display("%0t: taken_urgent expected %0d, got %0d", $time, want.urg, taken_urgent);
					errors++;
				end
				if (class_count !== want.count) begin
					$display("%0t: class_count expected %0d, got %0d", $time, want.count, class_count);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Sends one input beat. Valid is only lowered when the sender decides to idle,
	// so back-to-back beats keep it high. The expected result is computed at the
	// edge where the beat is accepted, which keeps prediction in acceptance order.
	task automatic send_beat(input logic op, input logic [CLASS_W-1:0] cls, input logic urg,
			input logic [TAG_FIELD_W-1:0] tag);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		class_index <= cls;
		urgent      <= urg;
		entry_tag   <= tag;
		do @(posedge clk); while (!in_ready);
		outcomes_due.push_back(deque_outcome(op, cls, urg, tag));
		beats_sent++;
	endtask

	// Holds the sender off until every predicted result has come back.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
	endtask

	// Edge cases on two classes at the ends of the index range: empty take, tags at
	// their extremes and in alternating bit patterns, urgent inserts ahead of regular
	// entries, adds to a full class in both flavors, and draining back to empty.
	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_beat(OP_TAKE, 4'd15, 1'b0, 16'h0000);
		send_beat(OP_ADD,  4'd15, 1'b0, 16'h0000);
		send_beat(OP_ADD,  4'd15, 1'b0, 16'hFFFF);
		send_beat(OP_ADD,  4'd15, 1'b1, 16'hAAAA);
		send_beat(OP_ADD,  4'd15, 1'b1, 16'h5555);
		for (int i = 1; i <= 4; i++)
			send_beat(OP_ADD, 4'd15, 1'b0, TAG_FIELD_W'(i));
		send_beat(OP_ADD,  4'd15, 1'b0, 16'h1234);
		send_beat(OP_ADD,  4'd15, 1'b1, 16'h4321);
		for (int i = 0; i < SLOTS; i++)
			send_beat(OP_TAKE, 4'd15, 1'b0, 16'hFFFF);
		send_beat(OP_TAKE, 4'd15, 1'b1, 16'hFFFF);
		send_beat(OP_ADD,  4'd0,  1'b1, 16'hFFFF);
		send_beat(OP_TAKE, 4'd0,  1'b0, 16'h0000);
		wait_all_results();
	endtask

	// Random traffic in bursts. Each burst leans toward adds or takes and mostly hits
	// one class, so classes regularly fill up and drain to empty.
	task automatic test_random(input int send_idle, input int recv_stall, input int beats);
		int               add_pct;
		int               left;
		logic [CLASS_W-1:0] hot;
		logic [CLASS_W-1:0] cls;
		logic             op;
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		left      = beats;
		while (left > 0) begin
			add_pct = $urandom_range(85, 20);
			hot     = CLASS_W'($urandom_range(CLASSES - 1));
			for (int i = $urandom_range(30, 8); i > 0 && left > 0; i--) begin
				cls = ($urandom_range(99) < 70) ? hot : CLASS_W'($urandom_range(CLASSES - 1));
				op  = ($urandom_range(99) < add_pct) ? OP_ADD : OP_TAKE;
				send_beat(op, cls, 1'($urandom_range(1)), TAG_FIELD_W'($urandom_range(16'hFFFF)));
				left--;
			end
		end
		wait_all_results();
	endtask

	// The sender adds five entries to a class, then stops dead until all results are back
	// before taking the entries out again, with one more take from the now empty class.
	task automatic test_pause_until_drained();
		idle_pct  = 0;
		stall_pct = 25;
		for (int i = 0; i < 5; i++)
			send_beat(OP_ADD, 4'd7, 1'($urandom_range(1)), TAG_FIELD_W'($urandom_range(16'hFFFF)));
		wait_all_results();
		for (int i = 0; i < 6; i++)
			send_beat(OP_TAKE, 4'd7, 1'b0, TAG_FIELD_W'($urandom_range(16'hFFFF)));
		wait_all_results();
	endtask

	initial begin
		for (int c = 0; c < CLASSES; c++)
			fill_count[c] = 0;
		for (int k = 0; k < 4; k++)
			code_tally[k] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(0, 0, 130);
		test_pause_until_drained();
		test_random(49, 0, 130);
		test_random(0, 49, 130);
		test_random(12, 12, 130);

		// Anything left in flight has had its chance; keep the clock running
		// in case an extra result beat shows up.
		wait_all_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d beats across directed edge cases, a drained pause and four idling mixes.",
			beats_sent);
		$display("Results: %0d added, %0d refused as full, %0d taken, %0d from empty classes.",
			code_tally[RC_ADDED], code_tally[RC_FULL], code_tally[RC_TAKEN], code_tally[RC_EMPTY]);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: the slowest legal run is well under a tenth of this.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
